### rtl/core/adc_hysteresis_quantizer_defines.svh
// Assertion macros for the hysteresis quantizer checker.
`ifndef ADC_HYSTERESIS_QUANTIZER_DEFINES_SVH
`define ADC_HYSTERESIS_QUANTIZER_DEFINES_SVH

// a implies c in the next cycle, ignored while in reset
`define AHQ_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("ahq check failed");

// a implies c in the same cycle, ignored while in reset
`define AHQ_ASSERT_NOW(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("ahq check failed");

// a implies c in the next cycle, checked through reset as well
`define AHQ_ASSERT_ALWAYS_NEXT(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |=> (c)) \
    else $error("ahq check failed");

`endif

### rtl/core/ahq_pkg.sv
// Types and constants shared by the hysteresis quantizer modules.
`default_nettype none
package ahq_pkg;

  localparam int CHANNELS   = 64;
  localparam int CH_IN_W    = 6;
  localparam int CH_EXT_W   = 9;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIVISOR_W  = 16;
  localparam int DIVIDEND_W = SAMPLE_W + LEVEL_W;
  localparam int DIV_STEPS  = DIVIDEND_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEVEL,
    REG_MAX_LEVEL,
    REG_NOM_STEP,
    REG_GAIN_MULT,
    REG_GAIN_DIV
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] acc;
    logic [LEVEL_W-1:0]  lvl;
  } chan_entry_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/core/adc_hysteresis_quantizer.sv
// Per-channel ADC dead-band filter and quantizer, top level.
//
//   channel   dir  handshake             payload
//   in        in   in_valid/in_ready     channel, sample
//   out       out  out_valid/out_ready   quantized_value, raw_held, updated
//   cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A sample that changes its channel goes from accept through store read, a multiply
// step in the mid band only, the divider at two quotient bits per step, and writeback.
// A sample inside the dead band goes from store read straight to the result.
// One item is in work at a time; the next beat is taken once writeback is done.
// Reset clears the channel valid bits at once, so the store reads zero until written.
// A result waiting in the output register holds writeback until it is taken.
`default_nettype none
module adc_hysteresis_quantizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ahq_pkg::CH_IN_W-1:0]   channel,
  input  logic [ahq_pkg::SAMPLE_W-1:0]  sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ahq_pkg::LEVEL_W-1:0]   quantized_value,
  output logic [ahq_pkg::SAMPLE_W-1:0]  raw_held,
  output logic                          updated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ahq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ahq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ahq_pkg::*;

  logic [SAMPLE_W-1:0]  min_level;
  logic [SAMPLE_W-1:0]  max_level;
  logic [SAMPLE_W-1:0]  nom_step;
  logic [DIVISOR_W-1:0] gain_mult;
  logic [DIVISOR_W-1:0] gain_div;

  ctl_state_t state;
  ctl_state_t state_next;

  logic [CH_W-1:0]     ch_q;
  logic                rng_q;
  logic [SAMPLE_W-1:0] s_q;
  logic                mid_q;
  logic [SAMPLE_W-1:0] offset_q;
  logic [LEVEL_W-1:0]  res_lvl;
  logic [SAMPLE_W-1:0] res_acc;
  logic                res_upd;

  logic [CH_EXT_W-1:0] ch_ext;
  logic                in_acc;
  chan_entry_t         rd_entry;
  chan_entry_t         wr_entry;
  div_req_t            dreq;
  div_rsp_t            drsp;

  logic [SAMPLE_W-1:0] half;
  logic [SAMPLE_W-1:0] quarter;
  logic [SAMPLE_W-1:0] diff;
  logic                mid;
  logic                change;
  logic                out_free;
  logic                load_out;
  logic                store_we;
  logic [LEVEL_W-1:0]  div_lvl;

  assign cfg_ready = 1'b1;
  assign ch_ext    = CH_EXT_W'(channel);
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= '0;
      max_level <= SAMPLE_W'(4095);
      nom_step  <= SAMPLE_W'(32);
      gain_mult <= DIVISOR_W'(1);
      gain_div  <= DIVISOR_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_LEVEL: min_level <= cfg_data[SAMPLE_W-1:0];
        REG_MAX_LEVEL: max_level <= cfg_data[SAMPLE_W-1:0];
        REG_NOM_STEP:  nom_step  <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN_MULT: gain_mult <= cfg_data[DIVISOR_W-1:0];
        REG_GAIN_DIV:  gain_div  <= cfg_data[DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    half    = nom_step >> 1;
    quarter = nom_step >> 2;
    diff    = (s_q >= rd_entry.acc) ? SAMPLE_W'(s_q - rd_entry.acc)
                                    : SAMPLE_W'(rd_entry.acc - s_q);
    mid     = (({1'b0, s_q} + {1'b0, half}) < {1'b0, max_level}) &&
              ({1'b0, s_q} > ({1'b0, min_level} + {1'b0, half}));
    change  = mid ? (diff >= half) : (diff >= quarter);
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    if (mid_q) begin
      div_lvl = (drsp.quotient >= DIVIDEND_W'(65535)) ? '1
              : LEVEL_W'(drsp.quotient[LEVEL_W-1:0] + 1'b1);
    end else begin
      div_lvl = (drsp.quotient[DIVIDEND_W-1:LEVEL_W] != '0) ? '1
              : drsp.quotient[LEVEL_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_READ;
      ST_READ: begin
        if (!rng_q || !change) state_next = ST_DONE;
        else if (mid)          state_next = ST_MUL;
        else                   state_next = ST_DIV;
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (drsp.done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    load_out      = 1'b0;
    store_we      = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = DIVIDEND_W'(s_q);
    dreq.divisor  = DIVISOR_W'(nom_step);
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_READ: dreq.start = rng_q && change && !mid;
      ST_MUL: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIVIDEND_W'(offset_q) * DIVIDEND_W'(gain_mult);
        dreq.divisor  = gain_div;
      end
      ST_DIV: ;
      ST_DONE: begin
        load_out = out_free;
        store_we = out_free && res_upd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_q  <= ch_ext[CH_W-1:0];
      rng_q <= ch_ext < CH_EXT_W'(CHANNELS);
      s_q   <= sample;
    end
    if (state == ST_READ) begin
      mid_q    <= mid;
      offset_q <= SAMPLE_W'(s_q - half);
      res_upd  <= 1'b0;
      if (rng_q) begin
        res_lvl <= rd_entry.lvl;
        res_acc <= rd_entry.acc;
      end else begin
        res_lvl <= '0;
        res_acc <= '0;
      end
    end
    if (state == ST_DIV && drsp.done) begin
      res_lvl <= div_lvl;
      res_acc <= s_q;
      res_upd <= 1'b1;
    end
    if (load_out) begin
      quantized_value <= res_lvl;
      raw_held        <= res_acc;
      updated         <= res_upd;
    end
  end

  assign wr_entry.acc = res_acc;
  assign wr_entry.lvl = res_lvl;

  ahq_store u_store (
    .clk   (clk),
    .rst   (rst),
    .re    (in_acc),
    .raddr (ch_ext[CH_W-1:0]),
    .we    (store_we),
    .waddr (ch_q),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  ahq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

endmodule
`default_nettype wire

### rtl/core/ahq_store.sv
// Per-channel store of accepted sample and level, with reset-cleared valid bits.
`default_nettype none
module ahq_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      re,
  input  logic [ahq_pkg::CH_W-1:0]  raddr,
  input  logic                      we,
  input  logic [ahq_pkg::CH_W-1:0]  waddr,
  input  ahq_pkg::chan_entry_t      wdata,
  output ahq_pkg::chan_entry_t      rdata
);
  import ahq_pkg::*;

  chan_entry_t         mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  chan_entry_t         rd_mem;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_mem <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_mem : '0;

endmodule
`default_nettype wire

### rtl/core/ahq_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
`default_nettype none
module ahq_div (
  input  logic              clk,
  input  logic              rst,
  input  ahq_pkg::div_req_t req,
  output ahq_pkg::div_rsp_t rsp
);
  import ahq_pkg::*;

  logic [DIVIDEND_W-1:0] work;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    r1;
  logic [DIVISOR_W:0]    r2;
  logic                  ge1;
  logic                  ge2;
  logic [DIVISOR_W-1:0]  rem1;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] work_next;

  always_comb begin
    r1        = {rem, work[DIVIDEND_W-1]};
    ge1       = r1 >= {1'b0, dsr};
    rem1      = ge1 ? DIVISOR_W'(r1 - {1'b0, dsr}) : r1[DIVISOR_W-1:0];
    r2        = {rem1, work[DIVIDEND_W-2]};
    ge2       = r2 >= {1'b0, dsr};
    rem_next  = ge2 ? DIVISOR_W'(r2 - {1'b0, dsr}) : r2[DIVISOR_W-1:0];
    work_next = {work[DIVIDEND_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      dsr  <= req.divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule
`default_nettype wire

### rtl/core/ahq_checker.sv
// Port-level checks for the hysteresis quantizer, bound to the top level.
`default_nettype none
`include "adc_hysteresis_quantizer_defines.svh"
module ahq_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [ahq_pkg::LEVEL_W-1:0]   quantized_value,
  input wire [ahq_pkg::SAMPLE_W-1:0]  raw_held,
  input wire                          updated,
  input wire                          cfg_ready
);

  `AHQ_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, rst, !out_valid && in_ready)
  `AHQ_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready ##1 !in_ready)
  `AHQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(quantized_value) && $stable(raw_held) && $stable(updated))
  `AHQ_ASSERT_NOW(a_cfg_open, clk, rst, 1'b1, cfg_ready)

endmodule

bind adc_hysteresis_quantizer ahq_checker u_ahq_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .quantized_value (quantized_value),
  .raw_held        (raw_held),
  .updated         (updated),
  .cfg_ready       (cfg_ready)
);
`default_nettype wire
